// ----- src/hcf_pkg.sv -----
`default_nettype none
package hcf_pkg;
  localparam int FRACTION_BITS = 8;
  localparam int HSL_BITS = 16;
  localparam int FW = FRACTION_BITS + 1;
  localparam int HW = HSL_BITS + 1;
  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRACTION_BITS;
  localparam logic [HW-1:0] HSL_ONE = HW'(1) << HSL_BITS;
  localparam int DNW = 12;
  localparam int DDW = 11;
  // Lightness is sum * 2^(HSL_BITS-1) / 255, taken as a multiply by a rounded-up reciprocal.
  localparam int LRW = HSL_BITS + 9;
  localparam logic [LRW-1:0] L_RECIP = LRW'(((64'd1 << (HSL_BITS + 16)) + 64'd254) / 64'd255);
  localparam int L_SHIFT = 17;

  typedef struct packed {
    logic [FW-1:0] t;
    logic [7:0]    ar, ag, ab, br, bg, bb;
  } in_t;

  typedef struct packed {
    logic [7:0] r, g, b;
  } rgb_t;

  typedef struct packed {
    logic [HW-1:0] h, s, l;
  } hsl_t;

  typedef struct packed {
    logic [8:0]  num_s;
    logic [8:0]  den_s;
    logic [11:0] num_h;
    logic [10:0] den_h;
    logic [8:0]  sum;
    logic        sat_zero;
    logic        hue_zero;
  } prep_t;

  function automatic prep_t prep(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
    prep_t p;
    logic [7:0] mx, mn, c;
    logic [8:0] sum;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    p.sum = sum;
    p.num_s = {1'b0, c};
    p.den_s = (sum > 9'd255) ? (9'd510 - sum) : sum;
    p.sat_zero = (sum == 9'd0) || (sum == 9'd510);
    p.hue_zero = (c == 8'd0);
    p.den_h = 11'(c) * 11'd6;
    if (mx == r) begin
      p.num_h = (g >= b) ? 12'(g - b) : (12'(c) * 12'd6 - 12'(b - g));
    end else if (mx == g) begin
      p.num_h = 12'(c) * 12'd2 + 12'(b) - 12'(r);
    end else begin
      p.num_h = 12'(c) * 12'd4 + 12'(r) - 12'(g);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

// ----- src/hcf_if.sv -----
`default_nettype none
interface hcf_in_if;
  logic         valid;
  logic         ready;
  hcf_pkg::in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hcf_out_if;
  logic          valid;
  logic          ready;
  hcf_pkg::rgb_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hcf_div.sv -----
`default_nettype none
// Pipelined restoring divider: quotient = floor(num * 2^HSL_BITS / den),
// one quotient bit per stage.
module hcf_div (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [hcf_pkg::DNW-1:0] num,
  input  wire logic [hcf_pkg::DDW-1:0] den,
  output logic [hcf_pkg::HW-1:0]       quo
);
  localparam int QB = hcf_pkg::HW;
  localparam int HB = hcf_pkg::HSL_BITS;
  localparam int DW = hcf_pkg::DDW;
  localparam int RW = hcf_pkg::DNW + HB + 1;
  logic [RW-1:0] rem_r [QB-1];
  logic [DW-1:0] den_r [QB-1];
  logic [QB-1:0] q_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic [RW-1:0] dsh;
    logic          take;
    if (i == 0) begin : g_first
      assign rem_in = RW'(num) << HB;
      assign den_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in = q_r[i-1];
    end
    assign dsh = RW'(den_in) << (QB - 1 - i);
    assign take = (rem_in >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= take ? (q_in | (QB'(1) << (QB - 1 - i))) : q_in;
      end
    end
    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? (rem_in - dsh) : rem_in;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[QB-1];
endmodule
`default_nettype wire

// ----- src/hsl_color_fade.sv -----
`default_nettype none
// HSL color fade. Each input transfer carries two RGB colors and a fade
// fraction; each output transfer carries the blended RGB color.
// Both colors are converted to HSL, the three components are blended
// linearly and the result is converted back to RGB.
// The long part of the pipeline is the bit-per-stage division for hue
// and saturation. Throughput is one transfer per cycle unless the
// receiver stalls. The pipeline advances as a whole
// whenever the output stage is empty or being taken, so a receiver stall
// freezes every stage and nothing is lost or repeated; in_ready then
// follows out_ready. Reset clears all valid bits; data registers keep
// whatever they hold.
// Divide stages cover scaled hue and saturation in parallel while the
// lightness, taken by a reciprocal multiply, travels beside them; the
// remaining stages do the blend multiplies, chroma, sector select and
// the scale to 8 bits.
module hsl_color_fade (
  input wire logic  clk,
  input wire logic  rst_n,
  hcf_in_if.sink    in_ch,
  hcf_out_if.source out_ch
);
  localparam int HW = hcf_pkg::HW;
  localparam int HB = hcf_pkg::HSL_BITS;
  localparam int FB = hcf_pkg::FRACTION_BITS;
  localparam int FW = hcf_pkg::FW;
  localparam int LPW = hcf_pkg::LRW + 9;
  localparam int SW = 4 + FW + HW + HW;
  localparam int NV = HW + 8;

  logic [NV-1:0] vld_r;
  logic          en;
  assign en = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  hcf_pkg::in_t in0_r;
  hcf_pkg::prep_t pa_r, pb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      in0_r <= in_ch.data;
      pa_r <= hcf_pkg::prep(in_ch.data.ar, in_ch.data.ag, in_ch.data.ab);
      pb_r <= hcf_pkg::prep(in_ch.data.br, in_ch.data.bg, in_ch.data.bb);
    end
  end

  logic [FW-1:0] t1;
  assign t1 = (in0_r.t > hcf_pkg::FRAC_ONE) ? hcf_pkg::FRAC_ONE : in0_r.t;

  logic [LPW-1:0] lpa, lpb;
  assign lpa = LPW'(pa_r.sum) * LPW'(hcf_pkg::L_RECIP);
  assign lpb = LPW'(pb_r.sum) * LPW'(hcf_pkg::L_RECIP);

  logic [SW-1:0] side_r [HW];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {pa_r.hue_zero, pa_r.sat_zero, pb_r.hue_zero, pb_r.sat_zero, t1,
                    lpa[hcf_pkg::L_SHIFT +: HW], lpb[hcf_pkg::L_SHIFT +: HW]};
      for (int i = 1; i < HW; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic          ha_zero, sa_zero, hb_zero, sb_zero;
  logic [FW-1:0] t2;
  logic [HW-1:0] la2, lb2;
  assign {ha_zero, sa_zero, hb_zero, sb_zero, t2, la2, lb2} = side_r[HW-1];

  logic [HW-1:0] qha, qhb, qsa, qsb;

  hcf_div u_dha (
    .clk, .en, .num(pa_r.num_h), .den(pa_r.den_h), .quo(qha));
  hcf_div u_dhb (
    .clk, .en, .num(pb_r.num_h), .den(pb_r.den_h), .quo(qhb));
  hcf_div u_dsa (
    .clk, .en, .num({3'b000, pa_r.num_s}),
    .den({2'b00, (pa_r.sat_zero ? 9'd1 : pa_r.den_s)}), .quo(qsa));
  hcf_div u_dsb (
    .clk, .en, .num({3'b000, pb_r.num_s}),
    .den({2'b00, (pb_r.sat_zero ? 9'd1 : pb_r.den_s)}), .quo(qsb));

  hcf_pkg::hsl_t ca_r, cb_r;
  logic [FW-1:0] t3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ca_r.h <= ha_zero ? '0 : qha;
      cb_r.h <= hb_zero ? '0 : qhb;
      ca_r.s <= sa_zero ? '0 : qsa;
      cb_r.s <= sb_zero ? '0 : qsb;
      ca_r.l <= la2;
      cb_r.l <= lb2;
      t3_r <= t2;
    end
  end

  localparam int BW = HW + FW;
  logic [BW-1:0] bh_a_r, bh_b_r, bs_a_r, bs_b_r, bl_a_r, bl_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      bh_a_r <= BW'(ca_r.h) * BW'(hcf_pkg::FRAC_ONE - t3_r);
      bh_b_r <= BW'(cb_r.h) * BW'(t3_r);
      bs_a_r <= BW'(ca_r.s) * BW'(hcf_pkg::FRAC_ONE - t3_r);
      bs_b_r <= BW'(cb_r.s) * BW'(t3_r);
      bl_a_r <= BW'(ca_r.l) * BW'(hcf_pkg::FRAC_ONE - t3_r);
      bl_b_r <= BW'(cb_r.l) * BW'(t3_r);
    end
  end

  logic [BW-1:0] bh_sum, bs_sum, bl_sum;
  assign bh_sum = bh_a_r + bh_b_r;
  assign bs_sum = bs_a_r + bs_b_r;
  assign bl_sum = bl_a_r + bl_b_r;

  logic [HW-1:0] h5_r, s5_r, l5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      h5_r <= bh_sum[FB +: HW];
      s5_r <= bs_sum[FB +: HW];
      l5_r <= bl_sum[FB +: HW];
    end
  end

  logic [HW:0] twol, dev;
  logic [HW-1:0] span;
  always_comb begin
    twol = {l5_r, 1'b0};
    dev = (twol >= (HW+1)'(hcf_pkg::HSL_ONE)) ? twol - (HW+1)'(hcf_pkg::HSL_ONE)
                                               : (HW+1)'(hcf_pkg::HSL_ONE) - twol;
    span = (dev >= (HW+1)'(hcf_pkg::HSL_ONE)) ? '0
                                               : HW'((HW+1)'(hcf_pkg::HSL_ONE) - dev);
  end

  logic [2*HW-1:0] cprod_r;
  logic [HW+2:0]   h6_r;
  logic [HW-1:0]   l6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cprod_r <= (2*HW)'(span) * (2*HW)'(s5_r);
      h6_r <= (HW+3)'(h5_r) * (HW+3)'(6);
      l6_r <= l5_r;
    end
  end

  logic [HW-1:0] chroma;
  logic [HW+2:0] sec_full;
  logic [2:0]    sector;
  logic [HW-1:0] fpart, wsel;
  always_comb begin
    chroma = cprod_r[HB +: HW];
    sec_full = h6_r >> HB;
    sector = (sec_full > (HW+3)'(5)) ? 3'd5 : sec_full[2:0];
    fpart = HW'(h6_r[HB-1:0]);
    wsel = sector[0] ? (hcf_pkg::HSL_ONE - fpart) : fpart;
  end

  logic [2*HW-1:0] xprod_r;
  logic [HW-1:0]   chroma7_r, base7_r;
  logic [2:0]      sec7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xprod_r <= (2*HW)'(chroma) * (2*HW)'(wsel);
      chroma7_r <= chroma;
      base7_r <= ((chroma >> 1) > l6_r) ? '0 : l6_r - (chroma >> 1);
      sec7_r <= sector;
    end
  end

  logic [HW:0] cc, xx, mm;
  logic [HW:0] rr_r, gg_r, bb_r;
  always_comb begin
    cc = (HW+1)'(chroma7_r) + (HW+1)'(base7_r);
    xx = (HW+1)'(xprod_r[HB +: HW]) + (HW+1)'(base7_r);
    mm = (HW+1)'(base7_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (sec7_r)
        3'd0: begin rr_r <= cc; gg_r <= xx; bb_r <= mm; end
        3'd1: begin rr_r <= xx; gg_r <= cc; bb_r <= mm; end
        3'd2: begin rr_r <= mm; gg_r <= cc; bb_r <= xx; end
        3'd3: begin rr_r <= mm; gg_r <= xx; bb_r <= cc; end
        3'd4: begin rr_r <= xx; gg_r <= mm; bb_r <= cc; end
        default: begin rr_r <= cc; gg_r <= mm; bb_r <= xx; end
      endcase
    end
  end

  function automatic logic [7:0] to_ch(input logic [HW:0] v);
    logic [HW+8:0] p;
    logic [HW+8:0] c;
    p = (HW+9)'(v) * (HW+9)'(255);
    c = p >> HB;
    return (c > (HW+9)'(255)) ? 8'd255 : c[7:0];
  endfunction

  hcf_pkg::rgb_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.r <= to_ch(rr_r);
      out_r.g <= to_ch(gg_r);
      out_r.b <= to_ch(bb_r);
    end
  end

  assign out_ch.valid = vld_r[NV-1];
  assign out_ch.data = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output drains");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready && !vld_r[NV-2] |=> !out_ch.valid)
    else $error("result invented");
endmodule
`default_nettype wire
